@@ src/sitb_pkg.sv @@
// Shared types and constants of the sorted id table.
package sitb_pkg;

    localparam int DEPTH_DEF        = 256;
    localparam int ID_WIDTH_DEF     = 32;
    localparam int HANDLE_WIDTH_DEF = 16;
    localparam int CAP_WIDTH        = 9;
    localparam int SLOT_OUT_WIDTH   = 8;
    localparam int FREE_WIDTH       = 8;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_NEXT   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_ORDER     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_ADD,
        FSM_SEARCH,
        FSM_SHIFT,
        FSM_OUT
    } fsm_t;

endpackage

@@ src/sorted_id_table_bsearch_core.sv @@
// Top level of the sorted id table with binary-search lookup.
// Sorted id table. Commands arrive as beats on s_axis; each yields one result beat on m_axis.
// Entries sit in one memory with a single write port and a registered read. An add runs as a
// read of the last entry, then compare and write, then the result; the unused command code
// goes straight to the result, as does a lookup in an empty table. A remove or get-next runs
// a binary search in which each probe has an address phase and then a compare phase, at most
// about log2(count)+2 probes, before the result; a remove then shifts each later entry down
// one slot (read then write) before the result. s_axis_tready stays low while a command runs
// and while the result beat waits, so it rises the cycle after the result is taken.
module sorted_id_table_bsearch_core #(
    parameter int DEPTH        = sitb_pkg::DEPTH_DEF,
    parameter int ID_WIDTH     = sitb_pkg::ID_WIDTH_DEF,
    parameter int HANDLE_WIDTH = sitb_pkg::HANDLE_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                            cfg_we,
    input  logic [sitb_pkg::CAP_WIDTH-1:0] cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // cmd[1:0], entry_id, entry_handle, zero fill
    input  logic [((2+ID_WIDTH+HANDLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status[1:0], slot_index[7:0], found_handle, found_id, free_slots[7:0], zero fill
    output logic [((2+8+HANDLE_WIDTH+ID_WIDTH+8+7)/8)*8-1:0] m_axis_tdata
);
    import sitb_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = AW + 1;
    localparam int MW   = ID_WIDTH + HANDLE_WIDTH;
    localparam int OUTW = ((2+8+HANDLE_WIDTH+ID_WIDTH+8+7)/8)*8;

    fsm_t state_reg, state_next;

    logic [CAP_WIDTH-1:0]    cap_reg;
    logic [CW-1:0]           count_reg;
    logic [ID_WIDTH-1:0]     cursor_reg;
    cmd_t                    cmd_reg;
    logic [ID_WIDTH-1:0]     key_reg;
    logic [HANDLE_WIDTH-1:0] hdl_reg;
    logic [CW-1:0]           lo_reg, hi_reg, probe_reg;
    logic                    phase_reg;   // 0: address issued, 1: data back
    logic [1:0]              tail_reg;    // search tail: 0 mid loop, 1 probe lo, 2 probe hi
    logic [OUTW-1:0]         out_data_reg;
    logic                    out_valid_reg;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [MW-1:0]           wr_data, rd_data;
    logic [ID_WIDTH-1:0]     rd_id;
    logic [HANDLE_WIDTH-1:0] rd_hdl;

    assign rd_id  = rd_data[MW-1:HANDLE_WIDTH];
    assign rd_hdl = rd_data[HANDLE_WIDTH-1:0];

    sitb_mem #(.DEPTH(DEPTH), .WIDTH(MW)) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // effective capacity and free count
    logic [CW:0] eff_cap;
    logic [CW:0] free_full;
    logic [FREE_WIDTH-1:0] free_cnt;
    always_comb
    begin
        if (cap_reg < CAP_WIDTH'(2))
            eff_cap = (CW+1)'(2);
        else if (32'(cap_reg) > DEPTH)
            eff_cap = (CW+1)'(DEPTH);
        else
            eff_cap = (CW+1)'(cap_reg);
        if ((CW+1)'(count_reg) + (CW+1)'(1) >= eff_cap)
            free_full = '0;
        else
            free_full = eff_cap - (CW+1)'(count_reg) - (CW+1)'(1);
        free_cnt = (free_full > (CW+1)'(255)) ? FREE_WIDTH'(255) : FREE_WIDTH'(free_full);
    end

    logic [CW-1:0] mid;
    assign mid = CW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);

    // probe chosen in the address phase of a search
    logic [CW-1:0] probe_sel;
    always_comb
    begin
        if (tail_reg == 2'd0 && hi_reg - lo_reg >= CW'(2))
            probe_sel = mid;
        else if (tail_reg == 2'd0)
            probe_sel = lo_reg;
        else
            probe_sel = hi_reg;
    end

    assign s_axis_tready = (state_reg == FSM_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    case (cmd_t'(s_axis_tdata[1:0]))
                        CMD_ADD:    state_next = FSM_ADD;
                        CMD_REMOVE: state_next = FSM_SEARCH;
                        CMD_NEXT:   state_next = FSM_SEARCH;
                        default:    state_next = FSM_OUT;
                    endcase
                end
            end
            default: state_next = state_reg;
        endcase
    end

    // datapath sequencer
    function automatic logic [OUTW-1:0] pack(input status_t st, input logic [CW-1:0] slot,
                                             input logic [HANDLE_WIDTH-1:0] h,
                                             input logic [ID_WIDTH-1:0] id,
                                             input logic [FREE_WIDTH-1:0] fr);
        logic [OUTW-1:0] r;
        r = '0;
        r[1:0] = st;
        r[9:2] = SLOT_OUT_WIDTH'({{8{1'b0}}, slot});
        r[10 +: HANDLE_WIDTH] = h;
        r[10+HANDLE_WIDTH +: ID_WIDTH] = id;
        r[10+HANDLE_WIDTH+ID_WIDTH +: FREE_WIDTH] = fr;
        return r;
    endfunction

    // memory port control; a search addresses its new probe right away
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (state_reg == FSM_SEARCH && !phase_reg)
            rd_addr = AW'(probe_sel);
        else
            rd_addr = AW'(probe_reg);
        if (state_reg == FSM_ADD && phase_reg)
        begin
            if (!((CW+1)'(count_reg) + (CW+1)'(1) >= eff_cap)
                && !(count_reg != '0 && key_reg <= rd_id))
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(count_reg);
                wr_data = {key_reg, hdl_reg};
            end
        end
        if (state_reg == FSM_SHIFT && phase_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(probe_reg - CW'(1));
            wr_data = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cap_reg       <= CAP_WIDTH'(256);
            count_reg     <= '0;
            cursor_reg    <= ID_WIDTH'(1);
            cmd_reg       <= CMD_NONE;
            key_reg       <= '0;
            hdl_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            probe_reg     <= '0;
            out_data_reg  <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            tail_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                FSM_IDLE:
                begin
                    state_reg <= state_next;
                    phase_reg <= 1'b0;
                    tail_reg  <= '0;
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        cmd_reg <= cmd_t'(s_axis_tdata[1:0]);
                        hdl_reg <= s_axis_tdata[2+ID_WIDTH +: HANDLE_WIDTH];
                        key_reg <= (cmd_t'(s_axis_tdata[1:0]) == CMD_NEXT)
                                   ? cursor_reg : s_axis_tdata[2 +: ID_WIDTH];
                        lo_reg  <= '0;
                        hi_reg  <= count_reg;
                        probe_reg <= (count_reg == '0) ? '0 : count_reg - CW'(1);
                    end
                end
                FSM_ADD:
                begin
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else
                    begin
                        if ((CW+1)'(count_reg) + (CW+1)'(1) >= eff_cap)
                            out_data_reg <= pack(ST_FULL, '0, '0, '0, free_cnt);
                        else if (count_reg != '0 && key_reg <= rd_id)
                            out_data_reg <= pack(ST_ORDER, '0, '0, '0, free_cnt);
                        else
                        begin
                            count_reg <= count_reg + CW'(1);
                            out_data_reg <= pack(ST_OK, count_reg, hdl_reg, key_reg,
                                                 free_cnt);
                        end
                        state_reg <= FSM_OUT;
                    end
                end
                FSM_SEARCH:
                begin
                    if (count_reg == '0)
                    begin
                        state_reg <= FSM_OUT;
                    end
                    else if (!phase_reg)
                    begin
                        // register the probe whose read is under way
                        phase_reg <= 1'b1;
                        probe_reg <= probe_sel;
                        if (tail_reg == 2'd0 && !(hi_reg - lo_reg >= CW'(2)))
                            tail_reg <= 2'd1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        if (rd_id == key_reg)
                        begin
                            out_data_reg <= pack(ST_OK, probe_reg, rd_hdl, rd_id, '0);
                            if (cmd_reg == CMD_REMOVE)
                            begin
                                count_reg <= count_reg - CW'(1);
                                probe_reg <= probe_reg + CW'(1);
                                state_reg <= FSM_SHIFT;
                            end
                            else
                            begin
                                cursor_reg <= cursor_reg + ID_WIDTH'(1);
                                state_reg  <= FSM_OUT;
                            end
                        end
                        else if (tail_reg == 2'd0)
                        begin
                            if (key_reg < rd_id) hi_reg <= probe_reg;
                            else lo_reg <= probe_reg;
                        end
                        else if (tail_reg == 2'd1 && hi_reg < count_reg)
                            tail_reg <= 2'd2;
                        else
                            state_reg <= FSM_OUT;
                    end
                end
                FSM_SHIFT:
                begin
                    // read slot probe, write it to probe-1; count already reduced
                    if (!phase_reg)
                    begin
                        if (probe_reg > count_reg)
                            state_reg <= FSM_OUT;
                        else
                            phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        probe_reg <= probe_reg + CW'(1);
                    end
                end
                FSM_OUT:
                begin
                    // free count reflects the count after the command
                    out_valid_reg <= 1'b1;
                    if (cmd_reg != CMD_ADD && out_data_reg[1:0] != ST_OK)
                        out_data_reg <= pack(ST_NOT_FOUND, '0, '0, '0, free_cnt);
                    else
                        out_data_reg[10+HANDLE_WIDTH+ID_WIDTH +: FREE_WIDTH] <= free_cnt;
                    state_reg <= FSM_IDLE;
                end
                default: state_reg <= FSM_IDLE;
            endcase
            // every accepted command starts with a not-found result
            if (state_reg == FSM_IDLE && s_axis_tvalid && s_axis_tready)
                out_data_reg <= pack(ST_NOT_FOUND, '0, '0, '0, '0);
        end
    end
endmodule

@@ src/sitb_mem.sv @@
// Entry memory: one write port, one registered read port.
module sitb_mem #(
    parameter int DEPTH = sitb_pkg::DEPTH_DEF,
    parameter int WIDTH = sitb_pkg::ID_WIDTH_DEF + sitb_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule

@@ tb/tb_sorted_id_table_bsearch_core.sv @@
// Testbench for the sorted id table: queued command beats, modeled table, checked result beats.
`timescale 1ns / 100ps

module tb_sorted_id_table_bsearch_core;
    import sitb_pkg::*;

    localparam int DEPTH = 256;
    localparam int IDW   = 32;
    localparam int HW    = 16;
    localparam int SW    = ((2 + IDW + HW + 7) / 8) * 8;
    localparam int MW    = ((2 + 8 + HW + IDW + 8 + 7) / 8) * 8;
    localparam int LIMIT = 4000000;
    // a remove near the head of a full table shifts up to 254 entries, each read then written
    localparam int DRAIN = 1200;

    typedef struct packed {
        logic [HW-1:0]  handle;
        logic [IDW-1:0] id;
        cmd_t           cmd;
    } beat_in_t;

    typedef struct packed {
        logic [7:0]     free_slots;
        logic [IDW-1:0] found_id;
        logic [HW-1:0]  found_handle;
        logic [7:0]     slot_index;
        status_t        status;
    } beat_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CAP_WIDTH-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [SW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [MW-1:0] m_axis_tdata;

    sorted_id_table_bsearch_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Table model
    logic [IDW-1:0] tbl_id [DEPTH];
    logic [HW-1:0]  tbl_handle [DEPTH];
    int             tbl_count;
    logic [IDW-1:0] cursor;
    logic [8:0]     capacity;

    beat_in_t  cmd_queue[$];
    beat_out_t result_queue[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_wait = 0;
    int  recv_wait = 0;

    function automatic int table_free();
        int c;
        int f;
        c = capacity;
        if (c < 2) c = 2;
        if (c > DEPTH) c = DEPTH;
        f = (tbl_count + 1 >= c) ? 0 : c - tbl_count - 1;
        return (f > 255) ? 255 : f;
    endfunction

    // Binary search in the same probe order as the table itself
    function automatic int table_find(logic [IDW-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_count;
        if (tbl_count == 0) return -1;
        while (hi - lo >= 2) begin
            mid = (lo + hi) / 2;
            if (tbl_id[mid] == key) return mid;
            if (key < tbl_id[mid]) hi = mid; else lo = mid;
        end
        if (tbl_id[lo] == key) return lo;
        if (hi < tbl_count && tbl_id[hi] == key) return hi;
        return -1;
    endfunction

    function automatic beat_out_t table_apply(beat_in_t b);
        beat_out_t r;
        int p;
        r = '0;
        r.status = ST_NOT_FOUND;
        case (b.cmd)
            CMD_ADD:
            begin
                if (tbl_count + 1 >= ((capacity < 2) ? 2 : (capacity > DEPTH) ? DEPTH : capacity))
                    r.status = ST_FULL;
                else if (tbl_count > 0 && b.id <= tbl_id[tbl_count-1])
                    r.status = ST_ORDER;
                else
                begin
                    tbl_id[tbl_count] = b.id;
                    tbl_handle[tbl_count] = b.handle;
                    r.slot_index = tbl_count[7:0];
                    r.found_handle = b.handle;
                    r.found_id = b.id;
                    tbl_count++;
                    r.status = ST_OK;
                end
            end
            CMD_REMOVE:
            begin
                p = table_find(b.id);
                if (p >= 0)
                begin
                    r.slot_index = p[7:0];
                    r.found_handle = tbl_handle[p];
                    r.found_id = tbl_id[p];
                    tbl_count--;
                    for (int i = p; i < tbl_count; i++)
                    begin
                        tbl_id[i] = tbl_id[i+1];
                        tbl_handle[i] = tbl_handle[i+1];
                    end
                    r.status = ST_OK;
                end
            end
            CMD_NEXT:
            begin
                p = table_find(cursor);
                if (p >= 0)
                begin
                    r.slot_index = p[7:0];
                    r.found_handle = tbl_handle[p];
                    r.found_id = tbl_id[p];
                    cursor = cursor + 1'b1;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.free_slots = table_free();
        return r;
    endfunction

    function automatic beat_in_t mk(cmd_t c, logic [IDW-1:0] id, logic [HW-1:0] h);
        beat_in_t b;
        b.cmd = c;
        b.id = id;
        b.handle = h;
        return b;
    endfunction

    // Back-to-back beats only in stretches; otherwise drop valid and wait out a gap
    function automatic bit send_wait_zero_ok();
        return (cmd_queue.size() == 0) || ($urandom_range(0, 1) == 0);
    endfunction

    // Driver: one beat per queue entry, some back to back, others after a random gap
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                result_queue.push_back(table_apply(cmd_queue.pop_front()));
                send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
                if (send_wait_zero_ok())
                    s_axis_tvalid <= 1'b0;
                else
                    s_axis_tdata <= SW'(cmd_queue[0]);
            end
            else if (!s_axis_tvalid)
            begin
                if (send_wait > 0)
                    send_wait <= send_wait - 1;
                else if (cmd_queue.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= SW'(cmd_queue[0]);
                end
            end
        end
    end

    // Monitor: random backpressure and field-by-field compare
    always @(posedge clk)
    begin
        beat_out_t got;
        beat_out_t exp_r;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = beat_out_t'(m_axis_tdata[2+8+HW+IDW+8-1:0]);
                if (result_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat %h", $realtime, m_axis_tdata);
                end
                else
                begin
                    exp_r = result_queue.pop_front();
                    if (got.status !== exp_r.status)
                    begin
                        errors++;
                        $display("%0t: status exp %0d got %0d", $realtime, exp_r.status,
                                 got.status);
                    end
                    if (got.slot_index !== exp_r.slot_index)
                    begin
                        errors++;
                        $display("%0t: slot_index exp %0d got %0d", $realtime,
                                 exp_r.slot_index, got.slot_index);
                    end
                    if (got.found_handle !== exp_r.found_handle)
                    begin
                        errors++;
                        $display("%0t: found_handle exp %h got %h", $realtime,
                                 exp_r.found_handle, got.found_handle);
                    end
                    if (got.found_id !== exp_r.found_id)
                    begin
                        errors++;
                        $display("%0t: found_id exp %h got %h", $realtime,
                                 exp_r.found_id, got.found_id);
                    end
                    if (got.free_slots !== exp_r.free_slots)
                    begin
                        errors++;
                        $display("%0t: free_slots exp %0d got %0d", $realtime,
                                 exp_r.free_slots, got.free_slots);
                    end
                end
                recv_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("sorted_id_table_bsearch_core: mismatch");
            $finish;
        end
    end

    task automatic wait_idle();
        while (cmd_queue.size() > 0 || s_axis_tvalid || result_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_capacity(logic [8:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        capacity = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic over a table: ascending adds, order errors, removes, walks, unused codes
    task automatic random_phase(int n, int id_span);
        logic [IDW-1:0] last_id;
        int r;
        last_id = $urandom_range(0, 50);
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                last_id = last_id + $urandom_range(1, id_span);
                if ($urandom_range(0, 30) == 0) last_id = $urandom;
                cmd_queue.push_back(mk(CMD_ADD, last_id, HW'($urandom)));
            end
            else if (r < 50)
                cmd_queue.push_back(mk(CMD_ADD, $urandom_range(0, 1) ? $urandom : last_id,
                                       HW'($urandom)));
            else if (r < 68)
                cmd_queue.push_back(mk(CMD_REMOVE,
                    last_id - $urandom_range(0, id_span * 4), HW'($urandom)));
            else if (r < 72)
                cmd_queue.push_back(mk(CMD_REMOVE, $urandom, HW'($urandom)));
            else if (r < 97)
                cmd_queue.push_back(mk(CMD_NEXT, $urandom, HW'($urandom)));
            else
                cmd_queue.push_back(mk(CMD_NONE, $urandom, HW'($urandom)));
        end
    endtask

    initial
    begin
        capacity = 9'd256;
        tbl_count = 0;
        cursor = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty lookups, id 0 into an empty table, order errors, extremes
        cmd_queue.push_back(mk(CMD_NEXT, '0, '0));
        cmd_queue.push_back(mk(CMD_REMOVE, '0, '0));
        cmd_queue.push_back(mk(CMD_NONE, '1, '1));
        cmd_queue.push_back(mk(CMD_ADD, '0, 16'hFFFF));
        cmd_queue.push_back(mk(CMD_ADD, '0, 16'h1234));
        cmd_queue.push_back(mk(CMD_ADD, 32'd1, 16'h0001));
        cmd_queue.push_back(mk(CMD_ADD, 32'd2, 16'h0002));
        cmd_queue.push_back(mk(CMD_NEXT, '0, '0));
        cmd_queue.push_back(mk(CMD_NEXT, '0, '0));
        cmd_queue.push_back(mk(CMD_NEXT, '0, '0));
        cmd_queue.push_back(mk(CMD_ADD, 32'hFFFF_FFFF, 16'hA5A5));
        cmd_queue.push_back(mk(CMD_ADD, 32'hFFFF_FFFE, 16'h5A5A));
        cmd_queue.push_back(mk(CMD_REMOVE, 32'd1, '0));
        cmd_queue.push_back(mk(CMD_REMOVE, 32'd1, '0));
        cmd_queue.push_back(mk(CMD_REMOVE, 32'hFFFF_FFFF, '0));
        cmd_queue.push_back(mk(CMD_REMOVE, '0, '0));
        cmd_queue.push_back(mk(CMD_REMOVE, 32'd2, '0));
        cmd_queue.push_back(mk(CMD_NONE, '0, '0));
        wait_idle();

        // Tiny capacity: full refusals, then capacity lowered below the count
        set_capacity(9'd0);
        for (int k = 0; k < 4; k++) cmd_queue.push_back(mk(CMD_ADD, 32'd10 + k, HW'(k)));
        wait_idle();
        set_capacity(9'd8);
        for (int k = 0; k < 8; k++) cmd_queue.push_back(mk(CMD_ADD, 32'd20 + k, HW'(k)));
        wait_idle();
        set_capacity(9'd3);
        cmd_queue.push_back(mk(CMD_ADD, 32'd99, '0));
        cmd_queue.push_back(mk(CMD_REMOVE, 32'd23, '0));
        cmd_queue.push_back(mk(CMD_REMOVE, 32'd10, '0));
        wait_idle();

        // Capacity above DEPTH, then random phases at several settings
        set_capacity(9'd511);
        random_phase(400, 3);
        wait_idle();
        set_capacity(9'd2);
        random_phase(100, 2);
        wait_idle();
        set_capacity(9'd40);
        random_phase(300, 2);
        wait_idle();
        set_capacity(9'd256);
        random_phase(400, 1000);
        wait_idle();

        if (errors == 0)
            $display("sorted_id_table_bsearch_core: match");
        else
            $display("sorted_id_table_bsearch_core: mismatch");
        $finish;
    end
endmodule

@@ files.f @@
src/sitb_pkg.sv
src/sitb_mem.sv
src/sorted_id_table_bsearch_core.sv
tb/tb_sorted_id_table_bsearch_core.sv
